### rtl/dcnc_pkg.sv
`default_nettype none
package dcnc_pkg;
	localparam int MAX_POINTS = 1024;
	localparam int IDX_W = 10;
	localparam int CRD_W = 16;
	localparam int EPS_W = 35;
	localparam int MINP_W = 11;
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;
	localparam logic CFG_EPS = 1'b0;
	localparam logic CFG_MINP = 1'b1;

	typedef struct packed {
		logic operation;
		logic signed [CRD_W-1:0] x_coord;
		logic signed [CRD_W-1:0] y_coord;
		logic last_point;
		logic [IDX_W-1:0] read_index;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0] point_index;
		logic signed [CRD_W-1:0] x_out;
		logic signed [CRD_W-1:0] y_out;
		logic is_outlier;
		logic index_error;
	} rsp_t;
endpackage
`default_nettype wire

### rtl/dcnc_near.sv
`default_nettype none
module dcnc_near (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	input wire signed [dcnc_pkg::CRD_W-1:0] ax,
	input wire signed [dcnc_pkg::CRD_W-1:0] ay,
	input wire signed [dcnc_pkg::CRD_W-1:0] bx,
	input wire signed [dcnc_pkg::CRD_W-1:0] by,
	input wire [dcnc_pkg::EPS_W-1:0] eps,
	output logic near_valid,
	output logic near
);
	import dcnc_pkg::*;
	logic [CRD_W:0] dx_s1, dy_s1;
	logic [2*CRD_W+1:0] sx_s2, sy_s2;
	logic v_s1, v_s2;
	logic signed [CRD_W:0] dx, dy;
	logic [2*CRD_W+2:0] sum;

	always_comb begin
		dx = (CRD_W+1)'(ax) - (CRD_W+1)'(bx);
		dy = (CRD_W+1)'(ay) - (CRD_W+1)'(by);
		sum = {1'b0, sx_s2} + {1'b0, sy_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			near_valid <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			near_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= dx[CRD_W] ? (CRD_W+1)'(-dx) : dx;
		dy_s1 <= dy[CRD_W] ? (CRD_W+1)'(-dy) : dy;
		sx_s2 <= dx_s1 * dx_s1;
		sy_s2 <= dy_s1 * dy_s1;
		near <= sum <= (2*CRD_W+3)'(eps);
	end
endmodule
`default_nettype wire

### rtl/density_core_noise_classifier_unit.sv
// Loads are taken in the idle state, one per cycle outside the clear pass and the
// classification passes. A read passes the READ and RWAIT states before its response
// is registered, and holds off requests until that is taken. After the last load, an
// all-pairs pass and a pass over core rows run through one distance unit, stalling
// requests. Reset clears the point count, the set-complete flag and the control state;
// the mark memories are cleared by a MAX_POINTS-entry pass on the first load of each set.
`default_nettype none
module density_core_noise_classifier_unit (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	output logic in_stall,
	input wire dcnc_pkg::req_t in_data,
	output logic out_valid,
	input wire out_stall,
	output dcnc_pkg::rsp_t out_data,
	input wire cfg_valid,
	output logic cfg_ready,
	input wire cfg_index,
	input wire [dcnc_pkg::EPS_W-1:0] cfg_data
);
	import dcnc_pkg::*;
	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = AW + 1;

	localparam logic [2:0] ST_IDLE = 3'd0, ST_CLEAR = 3'd1, ST_P1 = 3'd2,
		ST_P2 = 3'd3, ST_READ = 3'd4, ST_RWAIT = 3'd5;

	logic [CRD_W-1:0] xm [MAX_POINTS];
	logic [CRD_W-1:0] ym [MAX_POINTS];
	logic core_m [MAX_POINTS];
	logic reach_m [MAX_POINTS];

	logic [2:0] st_q;
	logic [EPS_W-1:0] eps_q;
	logic [MINP_W-1:0] minp_q;
	logic [CW-1:0] cnt_q;
	logic done_q;
	logic [CW-1:0] i_q, j_q;
	logic [AW-1:0] ia_q;
	logic [CRD_W-1:0] xi_q, yi_q, xr_q, yr_q;
	logic [CRD_W-1:0] xj_q, yj_q;
	logic core_r_q, reach_r_q, corei_q;
	logic [CW-1:0] ncount_q;
	logic [2:0] drain_q;
	logic [AW-1:0] jr_q, jd1_q, jd2_q, jd3_q;
	logic [3:0] jv_q;
	logic lastflag_q, need_clear_q;
	logic [IDX_W-1:0] ridx_q;
	logic rerr_q;
	logic dvalid, dnear;
	logic issue;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_W'(5898);
			minp_q <= MINP_W'(15);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_EPS: eps_q <= cfg_data;
				CFG_MINP: minp_q <= cfg_data[MINP_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall = (st_q != ST_IDLE) || out_valid;
	wire acc = in_valid && !in_stall;

	// Pair issue: j runs over all points; the row point i is held in registers.
	assign issue = (st_q == ST_P1 || st_q == ST_P2) && j_q < cnt_q && drain_q == 3'd0
		&& (st_q == ST_P1 || corei_q);

	dcnc_near u_near (
		.clk(clk), .arst_n(arst_n), .in_valid(jv_q[0]),
		.ax(xi_q), .ay(yi_q), .bx(xj_q), .by(yj_q), .eps(eps_q),
		.near_valid(dvalid), .near(dnear)
	);

	always_ff @(posedge clk) begin
		xj_q <= xm[j_q[AW-1:0]];
		yj_q <= ym[j_q[AW-1:0]];
		xr_q <= xm[ia_q];
		yr_q <= ym[ia_q];
		core_r_q <= core_m[ia_q];
		reach_r_q <= reach_m[ia_q];
		if (acc && in_data.operation == OP_LOAD && !(done_q) && cnt_q < CW'(MAX_POINTS)) begin
			xm[cnt_q[AW-1:0]] <= in_data.x_coord;
			ym[cnt_q[AW-1:0]] <= in_data.y_coord;
		end else if (acc && in_data.operation == OP_LOAD && done_q) begin
			xm[0] <= in_data.x_coord;
			ym[0] <= in_data.y_coord;
		end
		if (st_q == ST_CLEAR) begin
			core_m[i_q[AW-1:0]] <= 1'b0;
			reach_m[i_q[AW-1:0]] <= 1'b0;
		end else if (st_q == ST_P1 && drain_q == 3'd1) begin
			core_m[ia_q] <= ncount_q >= CW'(minp_q);
		end else if (st_q == ST_P2 && dvalid && dnear && jd3_q != ia_q) begin
			reach_m[jd3_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			ia_q <= '0;
			drain_q <= '0;
			jv_q <= '0;
			jr_q <= '0;
			jd1_q <= '0;
			jd2_q <= '0;
			jd3_q <= '0;
			ncount_q <= '0;
			out_valid <= 1'b0;
			out_data <= '0;
			lastflag_q <= 1'b0;
			need_clear_q <= 1'b1;
			corei_q <= 1'b0;
			xi_q <= '0;
			yi_q <= '0;
			ridx_q <= '0;
			rerr_q <= 1'b0;
		end else begin
			jv_q <= {jv_q[2:0], issue};
			jr_q <= j_q[AW-1:0];
			jd1_q <= jr_q;
			jd2_q <= jd1_q;
			jd3_q <= jd2_q;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (st_q == ST_P1 && dvalid && dnear && jd3_q != ia_q)
				ncount_q <= ncount_q + CW'(1);
			case (st_q)
				ST_IDLE: begin
					if (acc && in_data.operation == OP_LOAD) begin
						if (done_q || need_clear_q) begin
							cnt_q <= CW'(1);
							done_q <= 1'b0;
							st_q <= ST_CLEAR;
							i_q <= '0;
							need_clear_q <= 1'b0;
						end else if (cnt_q < CW'(MAX_POINTS)) begin
							cnt_q <= cnt_q + CW'(1);
						end
						lastflag_q <= in_data.last_point;
						if (!(done_q || need_clear_q) && in_data.last_point) begin
							st_q <= ST_P1;
							i_q <= '0;
							ia_q <= '0;
							j_q <= '0;
							drain_q <= 3'd3;
							ncount_q <= '0;
						end
					end else if (acc) begin
						ridx_q <= in_data.read_index;
						rerr_q <= !done_q || CW'(in_data.read_index) >= cnt_q;
						ia_q <= in_data.read_index[AW-1:0];
						st_q <= ST_READ;
					end
				end
				ST_CLEAR: begin
					if (i_q == CW'(MAX_POINTS - 1)) begin
						if (lastflag_q) begin
							st_q <= ST_P1;
							i_q <= '0;
							ia_q <= '0;
							j_q <= '0;
							drain_q <= 3'd3;
							ncount_q <= '0;
						end else
							st_q <= ST_IDLE;
					end else
						i_q <= i_q + CW'(1);
				end
				ST_P1, ST_P2: begin
					if (drain_q == 3'd3) begin
						drain_q <= 3'd2;
					end else if (drain_q == 3'd2) begin
						xi_q <= xr_q;
						yi_q <= yr_q;
						corei_q <= core_r_q;
						drain_q <= 3'd0;
					end else if (drain_q == 3'd0) begin
						if (issue) j_q <= j_q + CW'(1);
						else if (jv_q == '0 && !issue) drain_q <= 3'd1;
					end else begin
						ncount_q <= '0;
						j_q <= '0;
						if (i_q + CW'(1) >= cnt_q) begin
							i_q <= '0;
							ia_q <= '0;
							if (st_q == ST_P1) begin
								st_q <= ST_P2;
								drain_q <= 3'd3;
							end else begin
								st_q <= ST_IDLE;
								done_q <= 1'b1;
								drain_q <= 3'd0;
							end
						end else begin
							i_q <= i_q + CW'(1);
							ia_q <= AW'(i_q + CW'(1));
							drain_q <= 3'd3;
						end
					end
				end
				ST_READ: st_q <= ST_RWAIT;
				ST_RWAIT: begin
					out_valid <= 1'b1;
					out_data.point_index <= ridx_q;
					out_data.x_out <= rerr_q ? '0 : xr_q;
					out_data.y_out <= rerr_q ? '0 : yr_q;
					out_data.is_outlier <= !rerr_q && !core_r_q && !reach_r_q;
					out_data.index_error <= rerr_q;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(MAX_POINTS))
		else $error("count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_P1 || st_q == ST_P2) |-> !acc) else $error("accept during pass");
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_RWAIT |=> out_valid) else $error("read lost");
endmodule
`default_nettype wire
